@@ rtl/core/frpa_pkg.sv @@
// Shared types, codes and sizes for the fixed record pool allocator.
// No dependencies; every other file of the block but frpa_fifo imports it.
package frpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 17;
	localparam int CAP_W      = 11;
	localparam int IDX_OUT_W  = 10;
	localparam int SPAN_W     = SIZE_W + CAP_W;
	localparam int QUO_W      = CAP_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_MAX_RECORDS = 1024;
	localparam int CMD_DEPTH       = 2;
	localparam int RES_DEPTH       = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

	// Action codes of a request
	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Result status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] address;
	} request_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ADDR_W-1:0]    record_address;
		logic [IDX_OUT_W-1:0] record_index;
	} result_t;

	typedef enum logic [2:0] {
		CMD_ALLOC,
		CMD_FREE,
		CMD_CLEAR,
		CMD_REJECT,
		CMD_NOP
	} cmd_kind_t;

	// Classified command handed from front to back
	typedef struct packed {
		cmd_kind_t         kind;
		logic [SPAN_W-1:0] offset;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LINK,
		BK_DIV,
		BK_PUSH,
		BK_MUL,
		BK_ADD,
		BK_DONE
	} back_state_t;

endpackage

@@ rtl/core/frpa_fifo.sv @@
// Small synchronous queue of any packed type, used for commands and results.
// Depends on nothing but its parameters.
module frpa_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                   store_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/core/frpa_front.sv @@
// Front end: registers an incoming request, range-checks free addresses
// and hands a classified command to the command queue. Uses frpa_pkg.
module frpa_front
	import frpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  request_t          request,
	output logic              full,
	input  logic [ADDR_W-1:0] base,
	input  logic [SIZE_W-1:0] size_eff,
	input  logic [CAP_W-1:0]  cap_eff,
	output logic              cmd_push,
	output cmd_t              cmd,
	input  logic              cmd_full
);

	logic              s1_valid_q;
	request_t          req_s1;
	logic [SPAN_W-1:0] span_q;
	logic [ADDR_W:0]   diff;
	logic              out_of_range;
	logic              reject;

	assign full     = s1_valid_q & cmd_full;
	assign cmd_push = s1_valid_q & ~cmd_full;

	// Region span is a registered product of capacity and size
	always_ff @(posedge clk) begin
		span_q <= SPAN_W'(cap_eff) * SPAN_W'(size_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (push && !full) begin
			s1_valid_q <= 1'b1;
		end else if (cmd_push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			req_s1 <= request;
		end
	end

	assign diff         = {1'b0, req_s1.address} - {1'b0, base};
	assign out_of_range = (diff[ADDR_W-1:0] >= ADDR_W'(span_q));
	assign reject       = (req_s1.address == '0) | diff[ADDR_W] | out_of_range;

	always_comb begin
		cmd.offset = diff[SPAN_W-1:0];
		unique case (req_s1.action)
			ACT_ALLOC: cmd.kind = CMD_ALLOC;
			ACT_FREE:  cmd.kind = reject ? CMD_REJECT : CMD_FREE;
			ACT_CLEAR: cmd.kind = CMD_CLEAR;
			default:   cmd.kind = CMD_NOP;
		endcase
	end

endmodule

@@ rtl/core/frpa_back.sv @@
// Back end: sequencer that owns the free list, bump count and link memory,
// with a shared restoring divider and address multiplier. Uses frpa_pkg.
module frpa_back
	import frpa_pkg::*;
#(
	parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  logic [ADDR_W-1:0] base,
	input  logic [SIZE_W-1:0] size_eff,
	input  logic [CAP_W-1:0]  cap_eff,
	input  logic              res_full,
	output logic              res_push,
	output result_t           res
);

	localparam int IW = $clog2(MAX_RECORDS);
	localparam int HW = IW + 1;
	localparam int PW = IW + SIZE_W;
	localparam int KW = $clog2(QUO_W);
	localparam logic [HW-1:0] HEAD_NONE = HW'(MAX_RECORDS);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [HW-1:0]     head_q;
	logic [CAP_W-1:0]  used_q;
	logic [HW-1:0]     link_mem [MAX_RECORDS];
	logic [HW-1:0]     link_rd_q;
	logic [IW-1:0]     idx_q;
	logic [SPAN_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [KW-1:0]     k_q;
	logic [PW-1:0]     prod_q;
	result_t           res_q;
	logic              head_valid;
	logic              bump_ok;
	logic [SPAN_W-1:0] divisor_sh;
	logic              take;

	assign head_valid = (head_q != HEAD_NONE);
	assign bump_ok    = (used_q < cap_eff);
	assign divisor_sh = SPAN_W'(size_eff) << k_q;
	assign take       = (state_q == BK_IDLE) & cmd_valid;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						CMD_ALLOC: begin
							if (head_valid) begin
								state_d = BK_LINK;
							end else if (bump_ok) begin
								state_d = BK_MUL;
							end else begin
								state_d = BK_DONE;
							end
						end
						CMD_FREE: state_d = BK_DIV;
						default:  state_d = BK_DONE;
					endcase
				end
			end
			BK_LINK: state_d = BK_MUL;
			BK_DIV: begin
				if (k_q == '0) begin
					state_d = BK_PUSH;
				end
			end
			BK_PUSH: state_d = BK_DONE;
			BK_MUL:  state_d = BK_ADD;
			BK_ADD:  state_d = BK_DONE;
			BK_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Free list head and bump count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_NONE;
			used_q <= '0;
		end else begin
			if (take && cmd.kind == CMD_ALLOC && !head_valid && bump_ok) begin
				used_q <= used_q + 1'b1;
			end
			if (take && cmd.kind == CMD_CLEAR) begin
				used_q <= '0;
				head_q <= HEAD_NONE;
			end
			if (state_q == BK_LINK) begin
				head_q <= link_rd_q;
			end
			if (state_q == BK_PUSH) begin
				head_q <= HW'(quo_q);
			end
		end
	end

	// Link memory: one write port, one registered read port at the head
	always_ff @(posedge clk) begin
		if (state_q == BK_PUSH) begin
			link_mem[IW'(quo_q)] <= head_q;
		end
		link_rd_q <= link_mem[IW'(head_q)];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					res_q.record_address <= '0;
					res_q.record_index   <= '0;
					if (cmd.kind == CMD_ALLOC && !head_valid && !bump_ok) begin
						res_q.status <= STATUS_FULL;
					end else if (cmd.kind == CMD_REJECT) begin
						res_q.status <= STATUS_REJECT;
					end else begin
						res_q.status <= STATUS_OK;
					end
					rem_q <= cmd.offset;
					quo_q <= '0;
					k_q   <= KW'(QUO_W - 1);
					idx_q <= head_valid ? IW'(head_q) : IW'(used_q);
				end
			end
			BK_DIV: begin
				if (rem_q >= divisor_sh) begin
					rem_q      <= rem_q - divisor_sh;
					quo_q[k_q] <= 1'b1;
				end
				k_q <= k_q - 1'b1;
			end
			BK_PUSH: res_q.record_index <= IDX_OUT_W'(quo_q);
			BK_MUL:  prod_q <= PW'(idx_q) * PW'(size_eff);
			BK_ADD: begin
				res_q.record_address <= base + ADDR_W'(prod_q);
				res_q.record_index   <= IDX_OUT_W'(idx_q);
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/fixed_record_pool_allocator_core.sv @@
// Top level of the fixed record pool allocator: configuration registers,
// front end, command and result queues, back-end sequencer. Uses frpa_pkg.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------
//  request   | in        | push / full        | action, address
//  result    | out       | pop / empty        | status, record_address, index
//  config    | in        | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// Each item passes the front register and the command queue, then runs in
// the back sequencer: clear, reject, unused code and full go straight to the
// done state, a bump allocation runs multiply and add, a free-list allocation
// first reads the link memory, then multiplies and adds, and a free runs 11
// restoring divide steps on the shared divider, then the link write. The back
// sequencer handles one item at a time; it sets the sustained rate.
// Reset empties the free list, clears the bump count and both queues; the
// link memory is not cleared. Either side may stall: the command queue
// decouples front from back, the result queue holds finished items.
module fixed_record_pool_allocator_core
	import frpa_pkg::*;
#(
	parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  request_t              request,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [CAP_W-1:0]  cap_q;
	logic [SIZE_W-1:0] size_eff;
	logic [CAP_W-1:0]  cap_eff;

	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    res_push;
	logic    res_full;
	result_t res_in;

	// Configuration registers; an unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= SIZE_RESET;
			cap_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_ADDRESS: base_q <= cfg_wdata[ADDR_W-1:0];
				REG_RECORD_SIZE:  size_q <= cfg_wdata[SIZE_W-1:0];
				REG_CAPACITY:     cap_q  <= cfg_wdata[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero size counts as one byte; capacity saturates at the pool depth
	assign size_eff = (size_q == '0) ? SIZE_W'(1) : size_q;
	assign cap_eff  = (32'(cap_q) > 32'(MAX_RECORDS)) ? CAP_W'(MAX_RECORDS) : cap_q;

	frpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.full     (full),
		.base     (base_q),
		.size_eff (size_eff),
		.cap_eff  (cap_eff),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	frpa_fifo #(
		.T     (cmd_t),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	frpa_back #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_valid (~cmd_empty),
		.cmd_pop   (cmd_pop),
		.base      (base_q),
		.size_eff  (size_eff),
		.cap_eff   (cap_eff),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	frpa_fifo #(
		.T     (result_t),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

`ifndef ASSERT_OFF
	// The back end must never finish an item into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// The front end must never hand a command to a full command queue
	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into full queue");

	// A result that is not ok never carries an address
	a_fail_no_address: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != STATUS_OK) |-> (result.record_address == '0))
		else $error("failed result carries an address");
`endif

endmodule

@@ test/fixed_record_pool_allocator_checker.sv @@
`timescale 1ns / 1ps
// Checker for the fixed record pool allocator: mirrors the pool state and predicts each result.
// Watches the request, result and config channels of the core. Depends on frpa_pkg only.
module fixed_record_pool_allocator_checker
	import frpa_pkg::*;
#(
	parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  request_t              request,
	input  logic                  empty,
	input  logic                  pop,
	input  result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    pending,
	output int                    checked,
	output int                    full_seen,
	output int                    reject_seen
);

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  head_q;
	logic [CAP_W-1:0]  used_q;
	logic [CAP_W-1:0]  link_mem [MAX_RECORDS];
	result_t           expected_results [$];

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Apply one request to the mirrored pool and return the result it must produce.
	function automatic result_t pool_outcome(input request_t req);
		result_t          res;
		logic [31:0]      eff_size;
		logic [CAP_W-1:0] eff_cap;
		logic [63:0]      span;
		logic [63:0]      offset;
		logic [CAP_W-1:0] idx;
		res      = '0;
		eff_size = (size_q == '0) ? 32'd1 : 32'(size_q);
		eff_cap  = (cap_q > MAX_RECORDS) ? CAP_W'(MAX_RECORDS) : cap_q;
		case (req.action)
			ACT_ALLOC: begin
				if (head_q < MAX_RECORDS) begin
					idx    = head_q;
					head_q = link_mem[idx];
				end else if (used_q < eff_cap) begin
					idx    = used_q;
					used_q = used_q + 1'b1;
				end else begin
					idx        = '0;
					res.status = STATUS_FULL;
				end
				if (res.status == STATUS_OK) begin
					res.record_address = base_q + 32'(idx) * eff_size;
					res.record_index   = idx[IDX_OUT_W-1:0];
				end
			end
			ACT_FREE: begin
				span   = 64'(eff_cap) * 64'(eff_size);
				offset = 64'(req.address) - 64'(base_q);
				if (req.address == '0 || req.address < base_q || offset >= span) begin
					res.status = STATUS_REJECT;
				end else begin
					idx           = CAP_W'(offset / 64'(eff_size));
					link_mem[idx] = head_q;
					head_q        = idx;
					res.record_index = idx[IDX_OUT_W-1:0];
				end
			end
			ACT_CLEAR: begin
				used_q = '0;
				head_q = CAP_W'(MAX_RECORDS);
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			base_q      = '0;
			size_q      = SIZE_RESET;
			cap_q       = '0;
			head_q      = CAP_W'(MAX_RECORDS);
			used_q      = '0;
			expected_results.delete();
			mismatches  = 0;
			checked     = 0;
			full_seen   = 0;
			reject_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_ADDRESS: base_q = cfg_wdata[ADDR_W-1:0];
					REG_RECORD_SIZE:  size_q = cfg_wdata[SIZE_W-1:0];
					REG_CAPACITY:     cap_q  = cfg_wdata[CAP_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding", longint'(result), 0);
				end else begin
					want = expected_results.pop_front();
					if (result.status != want.status)
						report_mismatch("status", result.status, want.status);
					if (result.record_address != want.record_address)
						report_mismatch("record_address", result.record_address,
							want.record_address);
					if (result.record_index != want.record_index)
						report_mismatch("record_index", result.record_index, want.record_index);
					if (want.status == STATUS_FULL)
						full_seen++;
					if (want.status == STATUS_REJECT)
						reject_seen++;
				end
				checked++;
			end
			if (push && !full)
				expected_results.push_back(pool_outcome(request));
		end
		pending = expected_results.size();
	end

endmodule

@@ test/fixed_record_pool_allocator_core_test.sv @@
`timescale 1ns / 1ps
// Top of the pool allocator testbench: clock, reset, stimulus and verdict.
// Instantiates fixed_record_pool_allocator_core and the checker beside it; uses frpa_pkg.
module fixed_record_pool_allocator_core_test;
	import frpa_pkg::*;

	localparam int ITEMS_PER_PHASE = 210;
	localparam int STALL_LIMIT     = 2000;  // cycles with no handshake on either channel
	localparam int DRAIN_CYCLES    = 30;    // longest item is well under this

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	request_t              request;
	logic                  full;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int mismatches;
	int pending;
	int checked;
	int full_seen;
	int reject_seen;

	int sent;
	int settings;
	int sender_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	// Current register values, kept to aim free addresses at the region.
	logic [ADDR_W-1:0] cur_base;
	logic [SIZE_W-1:0] cur_size;
	logic [CAP_W-1:0]  cur_cap;

	fixed_record_pool_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.request   (request),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	fixed_record_pool_allocator_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.request     (request),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked),
		.full_seen   (full_seen),
		.reject_seen (reject_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver: stall at random, at the rate of the current idling phase.
	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: end the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Stalled for %0d cycles with %0d results outstanding", idle_cycles, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one item; hold it until the core takes it. Returns at the accepting edge.
	task automatic send_request(input logic [1:0] action, input logic [ADDR_W-1:0] address);
		bit taken;
		taken = 1'b0;
		// Idling phases: sender slow / receiver slower, then swapped, then flat out.
		if (sent < 570) begin
			sender_idle_pct = 22;
			recv_idle_pct   = 49;
		end else if (sent < 1140) begin
			sender_idle_pct = 49;
			recv_idle_pct   = 22;
		end else begin
			sender_idle_pct = 0;
			recv_idle_pct   = 0;
		end
		while ($urandom_range(99) < sender_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		request <= '{action: action, address: address};
		while (!taken) begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end
		sent++;
	endtask

	// Drop push and hold off until every outstanding result has been popped.
	task automatic wait_for_results();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Write all three registers while the core is idle.
	task automatic apply_settings(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
			input logic [CAP_W-1:0] cap);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE_ADDRESS;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= REG_RECORD_SIZE;
		cfg_wdata <= CFG_DATA_W'(size);
		@(posedge clk);
		cfg_index <= REG_CAPACITY;
		cfg_wdata <= CFG_DATA_W'(cap);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_base = base;
		cur_size = size;
		cur_cap  = cap;
		settings++;
	endtask

	// Mostly well-formed traffic: allocations and frees that land inside the region,
	// with a share of out-of-region frees, clears and the unused action code.
	task automatic run_random_phase(input int count);
		logic [31:0]       eff_size;
		logic [31:0]       eff_cap;
		logic [31:0]       span;
		logic [31:0]       slot;
		logic [ADDR_W-1:0] addr;
		int                pick;
		eff_size = (cur_size == '0) ? 32'd1 : 32'(cur_size);
		eff_cap  = (cur_cap > DEF_MAX_RECORDS) ? DEF_MAX_RECORDS : 32'(cur_cap);
		span     = eff_cap * eff_size;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			// Now and then wait until every outstanding result has been popped before going on.
			if ($urandom_range(149) == 0)
				wait_for_results();
			if (pick < 45) begin
				send_request(ACT_ALLOC, $urandom);
			end else if (pick < 82 && eff_cap != 0) begin
				slot = $urandom_range(eff_cap - 1);
				addr = cur_base + slot * eff_size;
				if ($urandom_range(9) < 3)
					addr = addr + $urandom_range(eff_size - 1);
				send_request(ACT_FREE, addr);
			end else if (pick < 92) begin
				case ($urandom_range(4))
					0: addr = $urandom;
					1: addr = '0;
					2: addr = cur_base - 1'b1;
					3: addr = cur_base + span;
					default: addr = cur_base + span - 1'b1;
				endcase
				send_request(ACT_FREE, addr);
			end else if (pick < 95) begin
				send_request(ACT_CLEAR, $urandom);
			end else if (pick < 97) begin
				send_request(ACT_UNUSED, $urandom);
			end else begin
				send_request(ACT_FREE, $urandom);
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		push            = 1'b0;
		request         = '0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		sent            = 0;
		settings        = 0;
		sender_idle_pct = 0;
		recv_idle_pct   = 0;
		cur_base        = '0;
		cur_size        = SIZE_RESET;
		cur_cap         = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset settings: capacity zero, so allocate is full and every free is rejected.
		send_request(ACT_ALLOC, '0);
		send_request(ACT_FREE, 32'h0000_0010);

		// Small region: fill it, probe the borders, free twice, reuse, clear.
		apply_settings(32'h0000_1000, SIZE_W'(24), CAP_W'(4));
		repeat (5) send_request(ACT_ALLOC, 32'hFFFF_FFFF);
		send_request(ACT_FREE, 32'h0000_0000);           // null address
		send_request(ACT_FREE, 32'h0000_0FFF);           // just below the base
		send_request(ACT_FREE, 32'h0000_1000 + 96);      // one past the region end
		send_request(ACT_FREE, 32'h0000_1000 + 95);      // last byte, unaligned
		send_request(ACT_FREE, 32'h0000_1000 + 53);      // unaligned inside record two
		send_request(ACT_FREE, 32'h0000_1000 + 53);      // same record again
		repeat (4) send_request(ACT_ALLOC, '0);
		send_request(ACT_UNUSED, 32'hA5A5_5A5A);
		send_request(ACT_CLEAR, '0);
		send_request(ACT_ALLOC, '0);

		// Base near the top with capacity beyond the pool: addresses wrap past zero.
		apply_settings(32'hFFFF_FFF0, SIZE_W'(8), CAP_W'(2047));
		repeat (3) send_request(ACT_ALLOC, '0);
		send_request(ACT_FREE, 32'hFFFF_FFFF);

		// Random traffic over a spread of settings, extremes included.
		apply_settings(32'h0000_0000, SIZE_W'(8), CAP_W'(1024));
		run_random_phase(ITEMS_PER_PHASE);
		apply_settings($urandom, SIZE_W'(0), CAP_W'(16));
		run_random_phase(ITEMS_PER_PHASE);
		apply_settings($urandom, SIZE_W'(131071), CAP_W'(1024));
		run_random_phase(ITEMS_PER_PHASE);
		apply_settings(32'hFFFF_FFFF, SIZE_W'(1), CAP_W'(2047));
		run_random_phase(ITEMS_PER_PHASE);
		apply_settings($urandom, SIZE_W'($urandom_range(65536, 8)), CAP_W'(1));
		run_random_phase(ITEMS_PER_PHASE);
		apply_settings($urandom, SIZE_W'(8), CAP_W'(0));
		run_random_phase(ITEMS_PER_PHASE);
		apply_settings($urandom, SIZE_W'($urandom_range(131071)), CAP_W'($urandom_range(2047)));
		run_random_phase(ITEMS_PER_PHASE);
		apply_settings(32'h8000_0000, SIZE_W'(65536), CAP_W'(1024));
		run_random_phase(ITEMS_PER_PHASE);

		// Drain and let the back end settle before the verdict.
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests across %0d register settings; %0d results compared",
			sent, settings, checked);
		$display("Among them %0d pool-full allocations and %0d rejected frees",
			full_seen, reject_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/frpa_pkg.sv
rtl/core/frpa_fifo.sv
rtl/core/frpa_front.sv
rtl/core/frpa_back.sv
rtl/core/fixed_record_pool_allocator_core.sv
test/fixed_record_pool_allocator_checker.sv
test/fixed_record_pool_allocator_core_test.sv
